/* sv/mwo_pkg.sv */
// Package for the mecanum wheel odometry block: opcodes, widths, CORDIC constants.
// Depends on nothing; used by the interfaces and the top level.
`default_nettype none
package mwo_pkg;
    localparam int COUNT_W = 32;
    localparam int POS_W = 64;
    localparam int ANG_W = 32;
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESET = 1'b1;
    localparam logic CFG_LINEAR = 1'b0;
    localparam logic CFG_ROTATION = 1'b1;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic                 opcode;
        logic                 reading_ok;
        logic [COUNT_W-1:0]   count_front_left;
        logic [COUNT_W-1:0]   count_rear_left;
        logic [COUNT_W-1:0]   count_front_right;
        logic [COUNT_W-1:0]   count_rear_right;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [ANG_W-1:0]        heading;
        logic                    applied;
    } out_item_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051D;
                5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2E;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
                5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
                5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* sv/mwo_in_if.sv */
// Input channel interface: valid/ready plus one update or reset item.
// Depends on mwo_pkg.
`default_nettype none
interface mwo_in_if;
    logic              valid;
    logic              ready;
    mwo_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/mwo_out_if.sv */
// Output channel interface: valid/ready plus one pose result.
// Depends on mwo_pkg.
`default_nettype none
interface mwo_out_if;
    logic               valid;
    logic               ready;
    mwo_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/mecanum_wheel_odometry.sv */
// Top level of the mecanum wheel odometry block: deltas, serial multiplies, CORDIC, pose.
// Depends on mwo_pkg, mwo_in_if and mwo_out_if.
`default_nettype none
// One beat in, one beat out. An update runs the bit-serial scale multiplies
// (35x32 for dx and dy, 32x32 for dyaw, all together), then the iterative
// CORDIC of CORDIC_STEPS steps (24 by default), then four bit-serial 64x34
// rotation products, and then updates the pose; the result is held pending
// until it can move to the output register. A reset beat or a failed reading
// skips the arithmetic and goes straight to the pending result.
// The next beat is taken once the previous result has moved to the output
// register, so the output may stall while the next item is in work.
module mecanum_wheel_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    mwo_in_if.sink           in_ch,
    mwo_out_if.source        out_ch
);
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCALE, S_CORDIC, S_ROT, S_DONE
    } state_t;

    state_t              state_reg;
    logic [31:0]         lin_reg, rot_reg;
    logic [31:0]         last_reg [4];
    logic [63:0]         px_reg, py_reg;
    logic [31:0]         hd_reg;
    logic                out_valid_reg;
    mwo_pkg::out_item_t  out_reg;
    logic                res_pend_reg;
    logic                applied_reg;
    logic [5:0]          cnt_reg;
    logic [SW-1:0]       it_reg;
    logic [1:0]          ph_reg;
    // scale multiply operands
    logic [34:0]         sx_reg, sy_reg, sr_reg;
    logic [31:0]         mlin_reg, mrot_reg;
    logic [63:0]         dx_reg, dy_reg;
    logic [31:0]         dyaw_reg;
    // cordic
    logic signed [33:0]  cx_reg, cy_reg, cz_reg;
    logic [1:0]          quad_reg;
    logic signed [33:0]  cs_reg, sn_reg;
    // rotation products: shift the multiplier through 64 bits
    logic [63:0]         mpl_reg;
    logic [97:0]         acc_reg;
    logic [97:0]         sumx_reg, sumy_reg;

    logic signed [34:0]  d [4];
    logic [34:0]         sx_n, sy_n, sr_n;
    logic signed [33:0]  xs, ys;
    logic [31:0]         half, mid, shifted;
    logic signed [33:0]  mcand;
    logic [97:0]         mcand_ext;
    logic [63:0]         rx, ry;

    always_comb
    begin
        d[0] = 35'(signed'(in_ch.data.count_front_left - last_reg[0]));
        d[1] = 35'(signed'(in_ch.data.count_rear_left - last_reg[1]));
        d[2] = 35'(signed'(in_ch.data.count_front_right - last_reg[2]));
        d[3] = 35'(signed'(in_ch.data.count_rear_right - last_reg[3]));
        sx_n = 35'(d[0] + d[1] + d[2] + d[3]);
        sy_n = 35'(d[0] - d[1] + d[2] - d[3]);
        sr_n = 35'(d[2] + d[3] - d[0] - d[1]);
        xs = cx_reg >>> it_reg;
        ys = cy_reg >>> it_reg;
        half = {dyaw_reg[31], dyaw_reg[31:1]};
        mid = hd_reg + half;
        shifted = mid + 32'h20000000;
        case (ph_reg)
            2'd0: mcand = cs_reg;
            2'd1: mcand = -sn_reg;
            2'd2: mcand = sn_reg;
            default: mcand = cs_reg;
        endcase
        mcand_ext = 98'(signed'(mcand));
        rx = 64'((sumx_reg + 98'(1 << 29)) >> 30);
        ry = 64'((acc_reg + 98'(1 << 29)) >> 30);
    end

    assign in_ch.ready = (state_reg == S_IDLE) && !res_pend_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lin_reg <= '0;
            rot_reg <= '0;
            for (int k = 0; k < 4; k++) last_reg[k] <= '0;
            px_reg <= '0;
            py_reg <= '0;
            hd_reg <= '0;
            out_valid_reg <= 1'b0;
            res_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mwo_pkg::CFG_LINEAR: lin_reg <= cfg_data;
                    mwo_pkg::CFG_ROTATION: rot_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (res_pend_reg && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
                out_reg <= '{px_reg, py_reg, hd_reg, applied_reg};
                res_pend_reg <= 1'b0;
            end
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        if (in_ch.data.opcode == mwo_pkg::OP_RESET)
                        begin
                            for (int k = 0; k < 4; k++) last_reg[k] <= '0;
                            px_reg <= '0;
                            py_reg <= '0;
                            hd_reg <= '0;
                            applied_reg <= 1'b1;
                            res_pend_reg <= 1'b1;
                        end
                        else if (!in_ch.data.reading_ok)
                        begin
                            applied_reg <= 1'b0;
                            res_pend_reg <= 1'b1;
                        end
                        else
                        begin
                            last_reg[0] <= in_ch.data.count_front_left;
                            last_reg[1] <= in_ch.data.count_rear_left;
                            last_reg[2] <= in_ch.data.count_front_right;
                            last_reg[3] <= in_ch.data.count_rear_right;
                            sx_reg <= sx_n;
                            sy_reg <= sy_n;
                            sr_reg <= sr_n;
                            mlin_reg <= lin_reg;
                            mrot_reg <= rot_reg;
                            dx_reg <= '0;
                            dy_reg <= '0;
                            dyaw_reg <= '0;
                            cnt_reg <= '0;
                            state_reg <= S_SCALE;
                        end
                    end
                end
                S_SCALE:
                begin
                    // shift-add, one scale bit per cycle
                    if (mlin_reg[0])
                    begin
                        dx_reg <= dx_reg + (64'(signed'(sx_reg)) << cnt_reg[4:0]);
                        dy_reg <= dy_reg + (64'(signed'(sy_reg)) << cnt_reg[4:0]);
                    end
                    if (mrot_reg[0])
                        dyaw_reg <= dyaw_reg + (sr_reg[31:0] << cnt_reg[4:0]);
                    mlin_reg <= mlin_reg >> 1;
                    mrot_reg <= mrot_reg >> 1;
                    if (cnt_reg == 6'd31)
                    begin
                        state_reg <= S_CORDIC;
                        it_reg <= '0;
                        cx_reg <= mwo_pkg::CORDIC_X0;
                        cy_reg <= '0;
                        cz_reg <= '0;
                        cnt_reg <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_CORDIC:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        quad_reg <= shifted[31:30];
                        cz_reg <= 34'(signed'({1'b0, shifted[29:0]})) - 34'sh20000000;
                        cnt_reg <= 6'd1;
                    end
                    else if (it_reg == SW'(CORDIC_STEPS))
                    begin
                        unique case (quad_reg)
                            2'd0: begin cs_reg <= cx_reg; sn_reg <= cy_reg; end
                            2'd1: begin cs_reg <= -cy_reg; sn_reg <= cx_reg; end
                            2'd2: begin cs_reg <= -cx_reg; sn_reg <= -cy_reg; end
                            default: begin cs_reg <= cy_reg; sn_reg <= -cx_reg; end
                        endcase
                        ph_reg <= '0;
                        cnt_reg <= '0;
                        mpl_reg <= dx_reg;
                        acc_reg <= '0;
                        state_reg <= S_ROT;
                    end
                    else
                    begin
                        if (!cz_reg[33])
                        begin
                            cx_reg <= cx_reg - ys;
                            cy_reg <= cy_reg + xs;
                            cz_reg <= cz_reg - 34'(mwo_pkg::atan_turn(5'(it_reg)));
                        end
                        else
                        begin
                            cx_reg <= cx_reg + ys;
                            cy_reg <= cy_reg - xs;
                            cz_reg <= cz_reg + 34'(mwo_pkg::atan_turn(5'(it_reg)));
                        end
                        it_reg <= it_reg + SW'(1);
                    end
                end
                S_ROT:
                begin
                    // bit-serial signed multiply: top bit carries negative weight
                    if (cnt_reg == 6'd63)
                    begin
                        ph_reg <= ph_reg + 2'd1;
                        mpl_reg <= (ph_reg == 2'd0 || ph_reg == 2'd2) ? dy_reg : dx_reg;
                        if (ph_reg == 2'd1)
                        begin
                            sumx_reg <= acc_reg - ((mpl_reg[0]) ? (mcand_ext << 63) : '0);
                            acc_reg <= '0;
                        end
                        else if (mpl_reg[0])
                            acc_reg <= acc_reg - (mcand_ext << 63);
                        if (ph_reg == 2'd3) state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (mpl_reg[0])
                            acc_reg <= acc_reg + (mcand_ext << cnt_reg);
                        mpl_reg <= mpl_reg >> 1;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_DONE:
                begin
                    px_reg <= px_reg + rx;
                    py_reg <= py_reg + ry;
                    hd_reg <= hd_reg + dyaw_reg;
                    applied_reg <= 1'b1;
                    res_pend_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped");
    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        res_pend_reg |-> state_reg == S_IDLE)
        else $error("work while result pending");
`endif
endmodule
`default_nettype wire

/* tb/mecanum_wheel_odometry_checker.sv */
// Checker for the mecanum wheel odometry block: watches config writes and both channels,
// predicts each pose result and compares it field by field. Depends on mwo_pkg and the
// channel interfaces.
module mecanum_wheel_odometry_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    mwo_in_if           in_ch,
    mwo_out_if          out_ch,
    output int          fail_count,
    output int          pending
);
    localparam int STEPS = 24;

    logic [31:0] lin_scale;
    logic [31:0] rot_scale;
    logic [31:0] prev_count [4];
    logic [63:0] pose_x;
    logic [63:0] pose_y;
    logic [31:0] yaw;
    mwo_pkg::out_item_t pose_q [$];

    assign pending = pose_q.size();

    function automatic logic [31:0] atan_entry(int i);
        logic [31:0] tbl [32];
        tbl = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
                32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
                32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
                32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
        return tbl[i];
    endfunction

    task automatic heading_sincos(input logic [31:0] ang,
                                  output logic signed [63:0] c,
                                  output logic signed [63:0] s);
        logic [31:0]        rot;
        logic [1:0]         quad;
        logic signed [63:0] x, y, z, xs, ys;
        rot = ang + 32'h20000000;
        quad = rot[31:30];
        z = $signed({34'd0, rot[29:0]}) - 64'sd536870912;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - $signed({32'd0, atan_entry(i)});
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + $signed({32'd0, atan_entry(i)});
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_pose(input mwo_pkg::in_item_t it);
        mwo_pkg::out_item_t  res;
        logic [31:0]         cnt [4];
        logic signed [63:0]  d [4];
        logic signed [63:0]  sx, sy, sr, dx, dy, cs, sn;
        logic [31:0]         dyaw, mid;
        logic signed [127:0] acc;
        logic [31:0]         diff;
        res.applied = 1'b0;
        cnt = '{it.count_front_left, it.count_rear_left,
                it.count_front_right, it.count_rear_right};
        if (it.opcode == mwo_pkg::OP_RESET)
        begin
            foreach (prev_count[k]) prev_count[k] = '0;
            pose_x = '0; pose_y = '0; yaw = '0;
            res.applied = 1'b1;
        end
        else if (it.reading_ok)
        begin
            for (int k = 0; k < 4; k++)
            begin
                diff = cnt[k] - prev_count[k];
                d[k] = {{32{diff[31]}}, diff};
                prev_count[k] = cnt[k];
            end
            sx = d[0] + d[1] + d[2] + d[3];
            sy = d[0] - d[1] + d[2] - d[3];
            sr = -d[0] - d[1] + d[2] + d[3];
            dx = sx * $signed({32'd0, lin_scale});
            dy = sy * $signed({32'd0, lin_scale});
            dyaw = 32'(sr * $signed({32'd0, rot_scale}));
            mid = yaw + {dyaw[31], dyaw[31:1]};
            heading_sincos(mid, cs, sn);
            acc = 128'(dx) * 128'(cs) - 128'(dy) * 128'(sn) + (128'sd1 <<< 29);
            pose_x = pose_x + 64'(acc >>> 30);
            acc = 128'(dx) * 128'(sn) + 128'(dy) * 128'(cs) + (128'sd1 <<< 29);
            pose_y = pose_y + 64'(acc >>> 30);
            yaw = yaw + dyaw;
            res.applied = 1'b1;
        end
        res.pos_x = pose_x;
        res.pos_y = pose_y;
        res.heading = yaw;
        pose_q.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mwo_pkg::out_item_t want;
        if (!rst_n)
        begin
            lin_scale <= '0; rot_scale <= '0;
            foreach (prev_count[k]) prev_count[k] = '0;
            pose_x = '0; pose_y = '0; yaw = '0;
            pose_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == mwo_pkg::CFG_LINEAR)
                    lin_scale <= cfg_data;
                else
                    rot_scale <= cfg_data;
            end
            if (in_ch.valid && in_ch.ready)
                predict_pose(in_ch.data);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pose_q.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    want = pose_q.pop_front();
                    if (out_ch.data.pos_x !== want.pos_x)
                        report_mismatch("pos_x", out_ch.data.pos_x, want.pos_x);
                    if (out_ch.data.pos_y !== want.pos_y)
                        report_mismatch("pos_y", out_ch.data.pos_y, want.pos_y);
                    if (out_ch.data.heading !== want.heading)
                        report_mismatch("heading", out_ch.data.heading, want.heading);
                    if (out_ch.data.applied !== want.applied)
                        report_mismatch("applied", out_ch.data.applied, want.applied);
                end
            end
        end
    end
endmodule

/* tb/mecanum_wheel_odometry_tb.sv */
// Top of the mecanum wheel odometry testbench: clock, reset, config writes and encoder beats
// with random gaps and output stalls; the checker judges results. Depends on mwo_pkg, the
// channel interfaces, the block and mecanum_wheel_odometry_checker.
module mecanum_wheel_odometry_tb;
    localparam int LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          stall_mode;
    logic [31:0] enc [4];

    mwo_in_if  in_ch ();
    mwo_out_if out_ch ();

    mecanum_wheel_odometry u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    mecanum_wheel_odometry_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        if (stall_mode)
            out_ch.ready <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
        else
            out_ch.ready <= 1'b1;
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_beat(input logic op, input logic ok, input logic [31:0] c0,
                             input logic [31:0] c1, input logic [31:0] c2,
                             input logic [31:0] c3);
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{op, ok, c0, c1, c2, c3};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    function automatic logic [31:0] step_count(input logic [31:0] c, input int mode);
        case (mode)
            0: return c + ($urandom_range(0, 400) - 200);
            1: return c + $urandom_range(0, 70000) - 35000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int n);
        int mode;
        for (int i = 0; i < n; i++)
        begin
            mode = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
            foreach (enc[k]) enc[k] = step_count(enc[k], mode);
            if ($urandom_range(0, 39) == 0)
            begin
                send_beat(mwo_pkg::OP_RESET, 1'($urandom), $urandom, $urandom, $urandom,
                          $urandom);
                foreach (enc[k]) enc[k] = '0;
            end
            else
                send_beat(mwo_pkg::OP_UPDATE, $urandom_range(0, 9) != 0, enc[0], enc[1],
                          enc[2], enc[3]);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = mwo_pkg::CFG_LINEAR; cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.data = '0;
        out_ch.ready = 1'b0;
        stall_mode = 1'b0;
        cycle_count = 0;
        foreach (enc[k]) enc[k] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'd100, 32'd200, 32'd300, 32'd400);
        drain();
        write_reg(mwo_pkg::CFG_LINEAR, 32'h0001_0000);
        write_reg(mwo_pkg::CFG_ROTATION, 32'h0000_8000);
        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'd1000, 32'd1000, 32'd1000, 32'd1000);
        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'd0, 32'd2000, 32'd0, 32'd2000);
        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'd0, 32'd0, 32'd5000, 32'd5000);
        send_beat(mwo_pkg::OP_UPDATE, 1'b0, 32'hFFFF_FFFF, 32'd7, 32'd9, 32'd11);
        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000);
        send_beat(mwo_pkg::OP_RESET, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        send_beat(mwo_pkg::OP_RESET, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
        drain();
        write_reg(mwo_pkg::CFG_LINEAR, 32'hFFFF_FFFF);
        write_reg(mwo_pkg::CFG_ROTATION, 32'hFFFF_FFFF);
        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_0001);
        send_beat(mwo_pkg::OP_UPDATE, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                  32'hF0F0_F0F0);
        send_beat(mwo_pkg::OP_RESET, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
        foreach (enc[k]) enc[k] = '0;
        drain();

        write_reg(mwo_pkg::CFG_LINEAR, 32'h0100_0000);
        write_reg(mwo_pkg::CFG_ROTATION, 32'h0040_0000);
        random_phase(320);
        drain();
        write_reg(mwo_pkg::CFG_LINEAR, $urandom);
        write_reg(mwo_pkg::CFG_ROTATION, $urandom);
        random_phase(320);
        drain();
        write_reg(mwo_pkg::CFG_LINEAR, 32'hFFFF_FFFF);
        write_reg(mwo_pkg::CFG_ROTATION, 32'd0);
        random_phase(150);
        drain();
        write_reg(mwo_pkg::CFG_LINEAR, 32'd0);
        write_reg(mwo_pkg::CFG_ROTATION, 32'hFFFF_FFFF);
        random_phase(150);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
